// ===== rtl/core/utps_pkg.sv =====
package utps_pkg;

   localparam int NUM_REGS        = 6;
   localparam int DATA_WIDTH      = 32;
   localparam int ADDR_WIDTH      = $clog2(NUM_REGS * 4);
   localparam int REG_INDEX_WIDTH = ADDR_WIDTH - 2;

   typedef enum logic [REG_INDEX_WIDTH-1:0] {
      REG_A_X,
      REG_A_Y,
      REG_B_X,
      REG_B_Y,
      REG_C_X,
      REG_C_Y
   } reg_index_type;

endpackage

// ===== rtl/core/utps_req_if.sv =====
interface utps_req_if #(
   parameter int FRACTION_WIDTH = 16
) ();
   logic                      valid;
   logic                      ready;
   logic [FRACTION_WIDTH-1:0] weight_toward_c;
   logic [FRACTION_WIDTH-1:0] weight_toward_b;

   modport source (output valid, output weight_toward_c, output weight_toward_b, input ready);
   modport sink (input valid, input weight_toward_c, input weight_toward_b, output ready);
endinterface

// ===== rtl/core/utps_rsp_if.sv =====
interface utps_rsp_if #(
   parameter int COORD_WIDTH = 16
) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] point_x;
   logic signed [COORD_WIDTH-1:0] point_y;
   logic                          was_reflected;

   modport source (output valid, output point_x, output point_y, output was_reflected,
                   input ready);
   modport sink (input valid, input point_x, input point_y, input was_reflected,
                 output ready);
endinterface

// ===== rtl/core/utps_csr.sv =====
module utps_csr #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [utps_pkg::ADDR_WIDTH-1:0]      paddr,
   input  logic [utps_pkg::DATA_WIDTH-1:0]      pwdata,
   output logic [utps_pkg::DATA_WIDTH-1:0]      prdata,
   output logic                                 pready,
   output logic signed [COORD_WIDTH-1:0]        vertex_a_x,
   output logic signed [COORD_WIDTH-1:0]        vertex_a_y,
   output logic signed [COORD_WIDTH-1:0]        vertex_b_x,
   output logic signed [COORD_WIDTH-1:0]        vertex_b_y,
   output logic signed [COORD_WIDTH-1:0]        vertex_c_x,
   output logic signed [COORD_WIDTH-1:0]        vertex_c_y
);

   logic [COORD_WIDTH-1:0]                   regs_ff [utps_pkg::NUM_REGS];
   logic [utps_pkg::REG_INDEX_WIDTH-1:0]     reg_index;
   logic                                     index_ok;
   logic                                     write_en;

   assign reg_index = paddr[utps_pkg::ADDR_WIDTH-1:2];
   assign index_ok  = reg_index < utps_pkg::REG_INDEX_WIDTH'(utps_pkg::NUM_REGS);
   assign write_en  = psel && penable && pwrite && index_ok;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < utps_pkg::NUM_REGS; i++) begin
            regs_ff[i] <= '0;
         end
      end else if (write_en) begin
         regs_ff[reg_index] <= pwdata[COORD_WIDTH-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (index_ok) begin
         prdata = utps_pkg::DATA_WIDTH'(regs_ff[reg_index]);
      end
   end

   assign vertex_a_x = regs_ff[utps_pkg::REG_A_X];
   assign vertex_a_y = regs_ff[utps_pkg::REG_A_Y];
   assign vertex_b_x = regs_ff[utps_pkg::REG_B_X];
   assign vertex_b_y = regs_ff[utps_pkg::REG_B_Y];
   assign vertex_c_x = regs_ff[utps_pkg::REG_C_X];
   assign vertex_c_y = regs_ff[utps_pkg::REG_C_Y];

endmodule

// ===== rtl/core/utps_blend.sv =====
// Two stages: edge-times-fraction products, then sum with A and round half up.
module utps_blend #(
   parameter int COORD_WIDTH    = 16,
   parameter int FRACTION_WIDTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [FRACTION_WIDTH-1:0]       weight_c,
   input  logic [FRACTION_WIDTH-1:0]       weight_b,
   input  logic signed [COORD_WIDTH-1:0]   a_x,
   input  logic signed [COORD_WIDTH-1:0]   a_y,
   input  logic signed [COORD_WIDTH-1:0]   b_x,
   input  logic signed [COORD_WIDTH-1:0]   b_y,
   input  logic signed [COORD_WIDTH-1:0]   c_x,
   input  logic signed [COORD_WIDTH-1:0]   c_y,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic signed [COORD_WIDTH+2:0]   p_x,
   output logic signed [COORD_WIDTH+2:0]   p_y
);

   localparam int DW = COORD_WIDTH + 1;
   localparam int PW = COORD_WIDTH + FRACTION_WIDTH + 2;
   localparam int NW = COORD_WIDTH + FRACTION_WIDTH + 3;
   localparam logic [NW-1:0] HALF = NW'(1) << (FRACTION_WIDTH - 1);

   logic                  valid1_ff, valid2_ff;
   logic                  load1, load2;
   logic signed [DW-1:0]  diff_cx, diff_cy, diff_bx, diff_by;
   logic signed [PW-1:0]  prod_cx_in, prod_cy_in, prod_bx_in, prod_by_in;
   logic signed [PW-1:0]  prod_cx_ff, prod_cy_ff, prod_bx_ff, prod_by_ff;
   logic signed [NW-1:0]  sum_x, sum_y;
   logic signed [COORD_WIDTH+2:0] p_x_in, p_y_in, p_x_ff, p_y_ff;

   assign load2    = !valid2_ff || out_ready;
   assign load1    = !valid1_ff || load2;
   assign in_ready = load1;

   assign diff_cx = {c_x[COORD_WIDTH-1], c_x} - {a_x[COORD_WIDTH-1], a_x};
   assign diff_cy = {c_y[COORD_WIDTH-1], c_y} - {a_y[COORD_WIDTH-1], a_y};
   assign diff_bx = {b_x[COORD_WIDTH-1], b_x} - {a_x[COORD_WIDTH-1], a_x};
   assign diff_by = {b_y[COORD_WIDTH-1], b_y} - {a_y[COORD_WIDTH-1], a_y};

   assign prod_cx_in = diff_cx * $signed({1'b0, weight_c});
   assign prod_cy_in = diff_cy * $signed({1'b0, weight_c});
   assign prod_bx_in = diff_bx * $signed({1'b0, weight_b});
   assign prod_by_in = diff_by * $signed({1'b0, weight_b});

   // A scaled onto the fraction grid plus both edge terms plus half an LSB
   assign sum_x = {{3{a_x[COORD_WIDTH-1]}}, a_x, {FRACTION_WIDTH{1'b0}}}
                + {prod_cx_ff[PW-1], prod_cx_ff} + {prod_bx_ff[PW-1], prod_bx_ff}
                + $signed(HALF);
   assign sum_y = {{3{a_y[COORD_WIDTH-1]}}, a_y, {FRACTION_WIDTH{1'b0}}}
                + {prod_cy_ff[PW-1], prod_cy_ff} + {prod_by_ff[PW-1], prod_by_ff}
                + $signed(HALF);

   assign p_x_in = sum_x[NW-1:FRACTION_WIDTH];
   assign p_y_in = sum_y[NW-1:FRACTION_WIDTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         if (load1) valid1_ff <= in_valid;
         if (load2) valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load1) begin
         prod_cx_ff <= prod_cx_in;
         prod_cy_ff <= prod_cy_in;
         prod_bx_ff <= prod_bx_in;
         prod_by_ff <= prod_by_in;
      end
      if (load2) begin
         p_x_ff <= p_x_in;
         p_y_ff <= p_y_in;
      end
   end

   assign out_valid = valid2_ff;
   assign p_x       = p_x_ff;
   assign p_y       = p_y_ff;

endmodule

// ===== rtl/core/utps_side.sv =====
// Three stages: cross products, side test and mirror select, saturation.
module utps_side #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic signed [COORD_WIDTH+2:0]   p_x,
   input  logic signed [COORD_WIDTH+2:0]   p_y,
   input  logic signed [COORD_WIDTH-1:0]   a_x,
   input  logic signed [COORD_WIDTH-1:0]   a_y,
   input  logic signed [COORD_WIDTH-1:0]   b_x,
   input  logic signed [COORD_WIDTH-1:0]   b_y,
   input  logic signed [COORD_WIDTH-1:0]   c_x,
   input  logic signed [COORD_WIDTH-1:0]   c_y,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic signed [COORD_WIDTH-1:0]   point_x,
   output logic signed [COORD_WIDTH-1:0]   point_y,
   output logic                            was_reflected
);

   localparam int CW = COORD_WIDTH;
   localparam int QW = CW + 3;
   localparam int DW = CW + 1;
   localparam int EW = CW + 4;
   localparam int MW = DW + EW;
   localparam int XW = MW + 1;
   localparam int SW = 2 * DW;
   localparam int YW = SW + 1;

   logic valid3_ff, valid4_ff, valid5_ff;
   logic load3, load4, load5;

   logic signed [DW-1:0] edge_x, edge_y, ab_x, ab_y;
   logic signed [EW-1:0] pb_x, pb_y;
   logic signed [MW-1:0] m1_in, m2_in, m1_ff, m2_ff;
   logic signed [SW-1:0] n1_in, n2_in, n1_ff, n2_ff;
   logic signed [QW-1:0] p3_x_ff, p3_y_ff;

   logic signed [XW-1:0] cross_p;
   logic signed [YW-1:0] cross_a;
   logic                 flip_in, flip4_ff;
   logic signed [EW-1:0] mir_x, mir_y;
   logic signed [EW-1:0] sel_x_in, sel_y_in, sel_x_ff, sel_y_ff;

   logic signed [CW-1:0] sat_x_in, sat_y_in, point_x_ff, point_y_ff;
   logic                 reflected_ff;

   assign load5    = !valid5_ff || out_ready;
   assign load4    = !valid4_ff || load5;
   assign load3    = !valid3_ff || load4;
   assign in_ready = load3;

   // cross products of edge BC with P-B and with A-B
   assign edge_x = {c_x[CW-1], c_x} - {b_x[CW-1], b_x};
   assign edge_y = {c_y[CW-1], c_y} - {b_y[CW-1], b_y};
   assign ab_x   = {a_x[CW-1], a_x} - {b_x[CW-1], b_x};
   assign ab_y   = {a_y[CW-1], a_y} - {b_y[CW-1], b_y};
   assign pb_x   = {p_x[QW-1], p_x} - {{4{b_x[CW-1]}}, b_x};
   assign pb_y   = {p_y[QW-1], p_y} - {{4{b_y[CW-1]}}, b_y};

   assign m1_in = edge_x * pb_y;
   assign m2_in = edge_y * pb_x;
   assign n1_in = edge_x * ab_y;
   assign n2_in = edge_y * ab_x;

   assign cross_p = {m1_ff[MW-1], m1_ff} - {m2_ff[MW-1], m2_ff};
   assign cross_a = {n1_ff[SW-1], n1_ff} - {n2_ff[SW-1], n2_ff};
   assign flip_in = (cross_p != '0) && (cross_a != '0)
                 && (cross_p[XW-1] != cross_a[YW-1]);

   assign mir_x = {{4{b_x[CW-1]}}, b_x} + {{4{c_x[CW-1]}}, c_x}
                - {p3_x_ff[QW-1], p3_x_ff};
   assign mir_y = {{4{b_y[CW-1]}}, b_y} + {{4{c_y[CW-1]}}, c_y}
                - {p3_y_ff[QW-1], p3_y_ff};

   assign sel_x_in = flip_in ? mir_x : {p3_x_ff[QW-1], p3_x_ff};
   assign sel_y_in = flip_in ? mir_y : {p3_y_ff[QW-1], p3_y_ff};

   // clamp: in range when all bits from the sign of the result upward agree
   always_comb begin
      sat_x_in = sel_x_ff[CW-1:0];
      if (!(&sel_x_ff[EW-1:CW-1]) && (|sel_x_ff[EW-1:CW-1])) begin
         sat_x_in = sel_x_ff[EW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end
      sat_y_in = sel_y_ff[CW-1:0];
      if (!(&sel_y_ff[EW-1:CW-1]) && (|sel_y_ff[EW-1:CW-1])) begin
         sat_y_in = sel_y_ff[EW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
         valid5_ff <= 1'b0;
      end else begin
         if (load3) valid3_ff <= in_valid;
         if (load4) valid4_ff <= valid3_ff;
         if (load5) valid5_ff <= valid4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load3) begin
         m1_ff   <= m1_in;
         m2_ff   <= m2_in;
         n1_ff   <= n1_in;
         n2_ff   <= n2_in;
         p3_x_ff <= p_x;
         p3_y_ff <= p_y;
      end
      if (load4) begin
         sel_x_ff <= sel_x_in;
         sel_y_ff <= sel_y_in;
         flip4_ff <= flip_in;
      end
      if (load5) begin
         point_x_ff   <= sat_x_in;
         point_y_ff   <= sat_y_in;
         reflected_ff <= flip4_ff;
      end
   end

   assign out_valid     = valid5_ff;
   assign point_x       = point_x_ff;
   assign point_y       = point_y_ff;
   assign was_reflected = reflected_ff;

endmodule

// ===== rtl/core/uniform_triangle_point_sampler_top.sv =====
// Uniform point-in-triangle sampler.
// Program vertices A, B, C (signed, Q8.8 at the default width) over the APB
// port: registers at byte offsets 0x00..0x14 in the order ax, ay, bx, by,
// cx, cy. Write them only while no request is in flight.
// Each request on req_ch carries two unsigned fractions; the response on
// rsp_ch carries the sampled point, saturated, and a flag set when the
// parallelogram point was mirrored through the midpoint of BC.
// The datapath has five stages (edge products, sum and round, cross
// products, side test and mirror, saturation), each ending in a register.
// Throughput: one request per cycle while rsp_ch is ready. Every stage holds
// while its successor is full; bubbles collapse, so req_ch stays ready while
// the output holds a response until all five stages are occupied.
// Reset clears all vertices to zero and empties the pipeline.
module uniform_triangle_point_sampler_top #(
   parameter int COORD_WIDTH    = 16,
   parameter int FRACTION_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   utps_req_if.sink                          req_ch,
   utps_rsp_if.source                        rsp_ch,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [utps_pkg::ADDR_WIDTH-1:0]   paddr,
   input  logic [utps_pkg::DATA_WIDTH-1:0]   pwdata,
   output logic [utps_pkg::DATA_WIDTH-1:0]   prdata,
   output logic                              pready
);

   logic signed [COORD_WIDTH-1:0] a_x, a_y, b_x, b_y, c_x, c_y;
   logic signed [COORD_WIDTH+2:0] p_x, p_y;
   logic                          mid_valid, mid_ready;

   utps_csr #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .vertex_a_x (a_x),
      .vertex_a_y (a_y),
      .vertex_b_x (b_x),
      .vertex_b_y (b_y),
      .vertex_c_x (c_x),
      .vertex_c_y (c_y)
   );

   utps_blend #(
      .COORD_WIDTH    (COORD_WIDTH),
      .FRACTION_WIDTH (FRACTION_WIDTH)
   ) u_blend (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .weight_c  (req_ch.weight_toward_c),
      .weight_b  (req_ch.weight_toward_b),
      .a_x       (a_x),
      .a_y       (a_y),
      .b_x       (b_x),
      .b_y       (b_y),
      .c_x       (c_x),
      .c_y       (c_y),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .p_x       (p_x),
      .p_y       (p_y)
   );

   utps_side #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_side (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (mid_valid),
      .in_ready      (mid_ready),
      .p_x           (p_x),
      .p_y           (p_y),
      .a_x           (a_x),
      .a_y           (a_y),
      .b_x           (b_x),
      .b_y           (b_y),
      .c_x           (c_x),
      .c_y           (c_y),
      .out_valid     (rsp_ch.valid),
      .out_ready     (rsp_ch.ready),
      .point_x       (rsp_ch.point_x),
      .point_y       (rsp_ch.point_y),
      .was_reflected (rsp_ch.was_reflected)
   );

endmodule

// ===== tb/sv/uniform_triangle_point_sampler_top_test.sv =====
`timescale 1ns / 100ps

module uniform_triangle_point_sampler_top_test;

   localparam int COORD_W      = 16;
   localparam int FRAC_W       = 16;
   localparam int PIPE_LATENCY = 5;
   localparam int ITEMS_PER_PHASE = 100;
   localparam int RANDOM_PHASES   = 6;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [FRAC_W-1:0]         fraction_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      logic      reflected;
   } sample_point_type;

   class triangle_scoreboard;
      coord_type        vertex [utps_pkg::NUM_REGS];
      sample_point_type point_q [$];
      int               failures;
      int               checked;
      int               reflected_count;
      int               clamped_count;

      function new();
         foreach (vertex[i]) vertex[i] = '0;
         failures        = 0;
         checked         = 0;
         reflected_count = 0;
         clamped_count   = 0;
      endfunction

      function void set_vertex(int index, coord_type value);
         if (index < utps_pkg::NUM_REGS) vertex[index] = value;
      endfunction

      function int pending();
         return point_q.size();
      endfunction

      // a + (c-a)*t1 + (b-a)*t2, rounded half up onto the coordinate grid
      static function longint blend(longint a, longint b, longint c, longint t1, longint t2);
         longint acc;
         acc = a * (longint'(1) <<< FRAC_W) + (c - a) * t1 + (b - a) * t2
               + (longint'(1) <<< (FRAC_W - 1));
         return acc >>> FRAC_W;
      endfunction

      static function longint cross_z(longint ux, longint uy, longint vx, longint vy);
         return ux * vy - uy * vx;
      endfunction

      static function coord_type clamp(longint v);
         longint top;
         top = (longint'(1) <<< (COORD_W - 1)) - 1;
         if (v > top) return coord_type'(top);
         if (v < -top - 1) return coord_type'(-top - 1);
         return coord_type'(v);
      endfunction

      function void note_request(fraction_type t1, fraction_type t2);
         longint           ax, ay, bx, by, cx, cy, px, py, side_p, side_a, top;
         sample_point_type pt;
         ax = vertex[utps_pkg::REG_A_X];
         ay = vertex[utps_pkg::REG_A_Y];
         bx = vertex[utps_pkg::REG_B_X];
         by = vertex[utps_pkg::REG_B_Y];
         cx = vertex[utps_pkg::REG_C_X];
         cy = vertex[utps_pkg::REG_C_Y];
         px = blend(ax, bx, cx, t1, t2);
         py = blend(ay, by, cy, t1, t2);
         side_p = cross_z(cx - bx, cy - by, px - bx, py - by);
         side_a = cross_z(cx - bx, cy - by, ax - bx, ay - by);
         // strictly opposite sides of line BC only; on the line stays put
         pt.reflected = (side_p < 0 && side_a > 0) || (side_p > 0 && side_a < 0);
         if (pt.reflected) begin
            px = bx + cx - px;
            py = by + cy - py;
            reflected_count++;
         end
         top = (longint'(1) <<< (COORD_W - 1)) - 1;
         if (px > top || px < -top - 1 || py > top || py < -top - 1) clamped_count++;
         pt.x = clamp(px);
         pt.y = clamp(py);
         point_q = {point_q, pt};
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         failures++;
      endtask

      task check_point(coord_type x, coord_type y, logic reflected);
         sample_point_type want;
         if (point_q.size() == 0) begin
            report($sformatf("response (%0d, %0d, %0b) with no request outstanding",
                             x, y, reflected));
         end else begin
            want = point_q.pop_front();
            checked++;
            if (x !== want.x)
               report($sformatf("point_x got %0d want %0d", x, want.x));
            if (y !== want.y)
               report($sformatf("point_y got %0d want %0d", y, want.y));
            if (reflected !== want.reflected)
               report($sformatf("was_reflected got %0b want %0b", reflected, want.reflected));
         end
      endtask
   endclass

   logic                            clock;
   logic                            reset   = 1'b1;
   logic                            psel    = 1'b0;
   logic                            penable = 1'b0;
   logic                            pwrite  = 1'b0;
   logic [utps_pkg::ADDR_WIDTH-1:0] paddr   = '0;
   logic [utps_pkg::DATA_WIDTH-1:0] pwdata  = '0;
   logic [utps_pkg::DATA_WIDTH-1:0] prdata;
   logic                            pready;
   bit                              steady  = 1'b0;
   int                              settings_used = 1;

   triangle_scoreboard sb = new();

   utps_req_if #(.FRACTION_WIDTH(FRAC_W)) req_if ();
   utps_rsp_if #(.COORD_WIDTH(COORD_W))   rsp_if ();

   uniform_triangle_point_sampler_top #(
      .COORD_WIDTH    (COORD_W),
      .FRACTION_WIDTH (FRAC_W)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_if),
      .rsp_ch  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   fraction_type corner_c [8] = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000,
                                  16'h8000, 16'h8001, 16'h7FFF, 16'h0001};
   fraction_type corner_b [8] = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
                                  16'h8000, 16'h8001, 16'h7FFF, 16'hFFFE};

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   always @(posedge clock) begin
      rsp_if.ready <= steady || ($urandom_range(99) >= 14);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            sb.note_request(req_if.weight_toward_c, req_if.weight_toward_b);
         if (rsp_if.valid && rsp_if.ready)
            sb.check_point(rsp_if.point_x, rsp_if.point_y, rsp_if.was_reflected);
      end
   end

   // upper data bits random; only the low coordinate bits count
   task automatic write_reg(int index, coord_type value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= utps_pkg::ADDR_WIDTH'(index * 4);
      pwdata  <= {16'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_vertex(index, value);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_triangle(coord_type ax, coord_type ay, coord_type bx, coord_type by,
                                 coord_type cx, coord_type cy);
      write_reg(utps_pkg::REG_A_X, ax);
      write_reg(utps_pkg::REG_A_Y, ay);
      write_reg(utps_pkg::REG_B_X, bx);
      write_reg(utps_pkg::REG_B_Y, by);
      write_reg(utps_pkg::REG_C_X, cx);
      write_reg(utps_pkg::REG_C_Y, cy);
      settings_used++;
   endtask

   task automatic send_request(fraction_type t1, fraction_type t2);
      int gap;
      gap = 0;
      if (!steady)
         while ($urandom_range(99) < 14) gap++;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid           <= 1'b1;
      req_if.weight_toward_c <= t1;
      req_if.weight_toward_b <= t2;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic send_corners(int count);
      for (int i = 0; i < count; i++) send_request(corner_c[i], corner_b[i]);
   endtask

   // let the pipeline empty out before touching the vertices again
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
      repeat (PIPE_LATENCY + 3) @(posedge clock);
   endtask

   function automatic fraction_type random_fraction();
      fraction_type corners [5] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001};
      if ($urandom_range(9) == 0) return corners[$urandom_range(4)];
      return fraction_type'($urandom);
   endfunction

   initial begin
      coord_type v [utps_pkg::NUM_REGS];
      int        kind;

      req_if.valid           <= 1'b0;
      req_if.weight_toward_c <= '0;
      req_if.weight_toward_b <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // all vertices at zero out of reset: fully degenerate
      send_corners(2);
      drain();

      // small skewed triangle, odd offsets exercise the half-LSB rounding
      write_triangle(-16'sh0180, 16'sh0041, 16'sh0A01, -16'sh0003, 16'sh0005, 16'sh0B7F);
      send_corners(8);
      drain();

      // vertices at the range extremes
      write_triangle(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
      send_corners(8);
      drain();

      // collinear with B == C: no mirror, parallelogram point clamps
      write_triangle(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
      send_corners(4);
      drain();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         kind   = phase % 3;
         steady = (phase == 3);
         foreach (v[i])
            v[i] = (kind == 0) ? coord_type'($urandom)
                               : coord_type'(int'($urandom_range(4095)) - 2048);
         if (kind == 2) begin
            case ($urandom_range(2))
               0: begin
                  v[utps_pkg::REG_C_X] = v[utps_pkg::REG_B_X];
                  v[utps_pkg::REG_C_Y] = v[utps_pkg::REG_B_Y];
               end
               1: begin
                  v[utps_pkg::REG_B_X] = v[utps_pkg::REG_A_X];
                  v[utps_pkg::REG_B_Y] = v[utps_pkg::REG_A_Y];
               end
               default: begin
                  v[utps_pkg::REG_C_X] = coord_type'(2 * int'(v[utps_pkg::REG_B_X])
                                                     - int'(v[utps_pkg::REG_A_X]));
                  v[utps_pkg::REG_C_Y] = coord_type'(2 * int'(v[utps_pkg::REG_B_Y])
                                                     - int'(v[utps_pkg::REG_A_Y]));
               end
            endcase
         end
         write_triangle(v[utps_pkg::REG_A_X], v[utps_pkg::REG_A_Y],
                        v[utps_pkg::REG_B_X], v[utps_pkg::REG_B_Y],
                        v[utps_pkg::REG_C_X], v[utps_pkg::REG_C_Y]);
         // addresses past the last vertex must not disturb anything
         write_reg(utps_pkg::NUM_REGS + int'($urandom_range(1)), coord_type'($urandom));
         repeat (ITEMS_PER_PHASE) send_request(random_fraction(), random_fraction());
         drain();
      end
      steady = 1'b0;

      $display("Sampled %0d points over %0d vertex settings (zero, extreme, degenerate, random).",
               sb.checked, settings_used);
      $display("%0d points mirrored through BC, %0d clamped to the coordinate range.",
               sb.reflected_count, sb.clamped_count);
      if (sb.failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/utps_pkg.sv
rtl/core/utps_req_if.sv
rtl/core/utps_rsp_if.sv
rtl/core/utps_csr.sv
rtl/core/utps_blend.sv
rtl/core/utps_side.sv
rtl/core/uniform_triangle_point_sampler_top.sv
tb/sv/uniform_triangle_point_sampler_top_test.sv
